// ----- design/swmt_pkg.sv -----
// Shared types, constants and helpers for the sliding-window median block.
// No dependencies; every design file imports this package.
package swmt_pkg;

  localparam int WINDOW_DEF = 11;  // default window depth
  localparam int TIME_W     = 32;  // timestamp width
  localparam int HELD_W     = 4;   // reported count width

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_LOAD
  } state_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic insert;  // take the new timestamp this cycle
    logic full;    // window already holds WINDOW entries
    logic step;    // run one compare-exchange phase
    logic odd;     // phase parity: pairs whose lower cell index has this parity
  } cell_ctl_t;

  // Lower/upper pair order: an empty cell counts as larger than any timestamp
  function automatic logic swap_needed(input logic              lo_vld,
                                       input logic [TIME_W-1:0] lo_val,
                                       input logic              hi_vld,
                                       input logic [TIME_W-1:0] hi_val);
    return (!lo_vld && hi_vld) || (lo_vld && hi_vld && (lo_val > hi_val));
  endfunction

endpackage

// ----- design/swmt_cell.sv -----
// One cell of the sorted timestamp chain: value, age and valid flag.
// Depends on swmt_pkg; instantiated by sliding_window_median_time.
module swmt_cell
  import swmt_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int IDX    = 0,
  parameter int AW     = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic              ins_here,
  input  logic [TIME_W-1:0] ins_val,
  input  logic              lo_vld,
  input  logic [TIME_W-1:0] lo_val,
  input  logic [AW-1:0]     lo_age,
  input  logic              hi_vld,
  input  logic [TIME_W-1:0] hi_val,
  input  logic [AW-1:0]     hi_age,
  output logic              vld,
  output logic [TIME_W-1:0] val,
  output logic [AW-1:0]     age
);

  localparam logic ODD_IDX = 1'(IDX % 2);
  localparam logic HAS_UP  = (IDX < WINDOW - 1);
  localparam logic HAS_DN  = (IDX > 0);
  localparam logic [AW-1:0] AGE_LAST = AW'(WINDOW - 1);

  logic swap_up;
  logic swap_dn;
  logic take_new;

  assign swap_up = ctl.step && HAS_UP && (ODD_IDX == ctl.odd) &&
                   swap_needed(vld, val, hi_vld, hi_val);
  assign swap_dn = ctl.step && HAS_DN && (ODD_IDX != ctl.odd) &&
                   swap_needed(lo_vld, lo_val, vld, val);
  // Full window: overwrite the oldest entry; otherwise fill the first empty cell
  assign take_new = ctl.full ? (vld && (age == AGE_LAST)) : ins_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.insert) begin
      if (take_new) begin
        vld <= 1'b1;
      end
    end else if (swap_up) begin
      vld <= hi_vld;
    end else if (swap_dn) begin
      vld <= lo_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (take_new) begin
        val <= ins_val;
        age <= '0;
      end else if (vld) begin
        age <= age + AW'(1);
      end
    end else if (swap_up) begin
      val <= hi_val;
      age <= hi_age;
    end else if (swap_dn) begin
      val <= lo_val;
      age <= lo_age;
    end
  end

endmodule

// ----- design/sliding_window_median_time.sv -----
// Sliding-window median time past. Each accepted word is inserted, then the WINDOW odd-even
// compare-exchange phases re-sort the cell chain, then the result is loaded into the output
// register; no new word is taken until that load, which waits while the output is stalled.
// Reset (rst, synchronous, active high) empties the window, clears the count and the
// output valid; held timestamps are not cleared.
// Depends on swmt_pkg and swmt_cell.
module sliding_window_median_time
  import swmt_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] block_time
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] median_time, [35:32] held_count, [39:36] zero
);

  localparam int CW = $clog2(WINDOW + 1);            // count, also phase counter
  localparam int AW = $clog2(WINDOW + 1);            // per-cell age
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [CW-1:0] CNT_FULL   = CW'(WINDOW);
  localparam logic [CW-1:0] PHASE_LAST = CW'(WINDOW - 1);

  state_t state, state_next;

  logic [CW-1:0] count;        // entries held
  logic [CW-1:0] phase;        // sort phase index
  cell_ctl_t     ctl;
  logic          accept;
  logic          load_out;
  logic          full;

  logic [TIME_W-1:0] median_time;
  logic [HELD_W-1:0] held_count;

  logic [WINDOW-1:0]              cell_vld;
  logic [WINDOW-1:0][TIME_W-1:0]  cell_val;
  logic [WINDOW-1:0][AW-1:0]      cell_age;
  logic [WINDOW-1:0]              ins_here;
  logic [IW-1:0]                  mid_idx;

  assign full   = (count == CNT_FULL);
  assign accept = s_tvalid && s_tready;
  // Median sits at sorted index count/2; count is nonzero once a word is in
  assign mid_idx = IW'(count >> 1);

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_SORT;
      ST_SORT: if (phase == PHASE_LAST) state_next = ST_LOAD;
      ST_LOAD: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Output and control decode
  always_comb begin
    s_tready   = 1'b0;
    load_out   = 1'b0;
    ctl.insert = 1'b0;
    ctl.full   = full;
    ctl.step   = 1'b0;
    ctl.odd    = phase[0];
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        ctl.insert = s_tvalid;
      end
      ST_SORT: ctl.step = 1'b1;
      ST_LOAD: load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count grows until the window fills; phase counts the compare-exchange phases of a sort pass
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      phase <= '0;
    end else begin
      if (accept && !full) begin
        count <= count + CW'(1);
      end
      if (accept) begin
        phase <= '0;
      end else if (ctl.step) begin
        phase <= phase + CW'(1);
      end
    end
  end

  // The chain: each cell trades contents with one neighbor per sort phase
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic              lo_vld, hi_vld;
    logic [TIME_W-1:0] lo_val, hi_val;
    logic [AW-1:0]     lo_age, hi_age;

    assign ins_here[i] = (count == CW'(i));

    if (i > 0) begin : g_lo
      assign lo_vld = cell_vld[i-1];
      assign lo_val = cell_val[i-1];
      assign lo_age = cell_age[i-1];
    end else begin : g_lo_edge
      assign lo_vld = 1'b0;
      assign lo_val = '0;
      assign lo_age = '0;
    end

    if (i < WINDOW - 1) begin : g_hi
      assign hi_vld = cell_vld[i+1];
      assign hi_val = cell_val[i+1];
      assign hi_age = cell_age[i+1];
    end else begin : g_hi_edge
      assign hi_vld = 1'b0;
      assign hi_val = '0;
      assign hi_age = '0;
    end

    swmt_cell #(
      .WINDOW (WINDOW),
      .IDX    (i),
      .AW     (AW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .ins_here (ins_here[i]),
      .ins_val  (s_tdata[TIME_W-1:0]),
      .lo_vld   (lo_vld),
      .lo_val   (lo_val),
      .lo_age   (lo_age),
      .hi_vld   (hi_vld),
      .hi_val   (hi_val),
      .hi_age   (hi_age),
      .vld      (cell_vld[i]),
      .val      (cell_val[i]),
      .age      (cell_age[i])
    );
  end

  // Output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median_time <= (count == '0) ? '0 : cell_val[mid_idx];
      held_count  <= HELD_W'(count);
    end
  end

  assign m_tdata = {4'b0000, held_count, median_time};

`ifndef ASSERT_OFF
  // Count never passes the window depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("held count above window depth");

  // Between items the occupied cells match the count
  a_cells_match_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(cell_vld) == 32'(count)))
    else $error("occupied cells disagree with count");

  // An accepted word always starts a sort pass from phase zero
  a_accept_sorts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SORT) && (phase == '0))
    else $error("accepted word did not start a sort pass");
`endif

endmodule

// ----- bench/mtp_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the sliding-window median block: watches both streams, keeps its own window
// of timestamps, predicts every result word and compares it. Depends on swmt_pkg.
module mtp_checker
  import swmt_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] block_time
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [31:0] median_time, [35:32] held_count, [39:36] zero
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [TIME_W-1:0] median;
    logic [HELD_W-1:0] count;
  } mtp_t;

  logic [TIME_W-1:0] held_times [WINDOW];  // circular store, arrival order
  int                held_n;
  int                oldest;
  mtp_t              expected_mtp [$];

  // Push one timestamp, drop the oldest once full, return the median time past.
  function automatic mtp_t advance_window(input logic [TIME_W-1:0] ts);
    logic [TIME_W-1:0] ordered [WINDOW];
    logic [TIME_W-1:0] v;
    int                j;
    mtp_t              r;
    if (held_n < WINDOW) begin
      held_times[(oldest + held_n) % WINDOW] = ts;
      held_n++;
    end else begin
      held_times[oldest] = ts;
      oldest = (oldest + 1) % WINDOW;
    end
    // Insertion sort of the held entries, oldest first
    for (int i = 0; i < held_n; i++) begin
      v = held_times[(oldest + i) % WINDOW];
      j = i;
      while (j > 0 && ordered[j-1] > v) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = v;
    end
    r.median = ordered[held_n / 2];
    r.count  = HELD_W'(held_n);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    mtp_t want;
    if (rst) begin
      expected_mtp.delete();
      held_n  = 0;
      oldest  = 0;
      pending = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_mtp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word %h", $time, m_tdata);
        end else begin
          want = expected_mtp[0];
          expected_mtp.delete(0);
          if (m_tdata[31:0] !== want.median || m_tdata[35:32] !== want.count ||
              m_tdata[39:36] !== 4'h0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: median %h count %0d pad %h, expected median %h count %0d pad 0",
                       $time, m_tdata[31:0], m_tdata[35:32], m_tdata[39:36],
                       want.median, want.count);
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_mtp.insert(expected_mtp.size(), advance_window(s_tdata));
      pending = expected_mtp.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the bench for the sliding-window median block: clock, reset, timestamp stimulus,
// result-side stalls and the verdict. Depends on swmt_pkg, the block and mtp_checker.
module tb_top;
  import swmt_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  logic        s_taken  = 1'b0;  // input word accepted at the last rising edge
  int          idle_pct  = 0;    // chance per cycle that the sender holds off
  int          stall_pct = 0;    // chance per cycle that the receiver stalls
  int          mismatches;
  int          pending;
  logic [31:0] chain_time;       // running base for realistic timestamps

  // Idle profiles per random phase: none, sender only, receiver only, both
  int idle_by_phase  [4] = '{0, 69, 0, 20};
  int stall_by_phase [4] = '{0, 0, 69, 20};

  // Directed words: extremes on an empty window, duplicates, a full window of
  // the maximum value, then minimum values pushed through a full window.
  logic [31:0] directed_words [25] = '{
    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h600D_0000, 32'h600D_0000, 32'h600D_0000,
    32'h600D_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };

  sliding_window_median_time DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  mtp_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Record the input handshake at the rising edge; the driver reads it at the falling edge.
  always @(posedge clk) begin
    s_taken <= s_tvalid && s_tready;
  end

  // Stall the result side at random, per the current profile.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one word; hold it until accepted. Optionally idle first, which lowers
  // tvalid before the word is offered.
  task automatic push_timestamp(input logic [31:0] ts);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ts;
    do @(negedge clk); while (!s_taken);
  endtask

  // Mix of realistic chain times, full-range values, a narrow range that forces
  // duplicates, and the extremes of the field.
  function automatic logic [31:0] pick_timestamp();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 40) begin
      chain_time = chain_time + $urandom_range(1200);
      return chain_time + $urandom_range(7200) - 32'd3600;
    end else if (kind < 65) begin
      return $urandom;
    end else if (kind < 85) begin
      return $urandom_range(7);
    end else begin
      case ($urandom_range(4))
        0:       return 32'h0000_0000;
        1:       return 32'h0000_0001;
        2:       return 32'hFFFF_FFFE;
        3:       return 32'h8000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
  endfunction

  initial begin
    chain_time = 32'd1_500_000_000 + $urandom_range(100_000_000);

    // Hold reset, then release it at a falling edge
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, no idling
    foreach (directed_words[i])
      push_timestamp(directed_words[i]);

    // Random part: four idle profiles, about a hundred words each
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      repeat (100) push_timestamp(pick_timestamp());
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every predicted word, then give stray words time to show up
    while (pending != 0) @(negedge clk);
    repeat (4 * (WINDOW_DEF + 2)) @(negedge clk);

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sliding_window_median_time.f -----
design/swmt_pkg.sv
design/swmt_cell.sv
design/sliding_window_median_time.sv
bench/mtp_checker.sv
bench/tb_top.sv
